/* sv/epl_pkg.sv */
`timescale 1ns / 1ps

package epl_pkg;

  // Default limits for the top-level parameters.
  localparam int unsigned LINE_MAX_DEF = 1024;
  localparam int unsigned LEAD_MAX_DEF = 32;

  // Characters that the extractor looks for.
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  // Source of the next beat loaded into the output register.
  typedef enum logic [2:0] {
    LOAD_NONE,
    LOAD_NOW,
    LOAD_REPLAY,
    LOAD_MAIN,
    LOAD_NL
  } load_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      accept;
    logic      replay_start;
    logic      replay_next;
    load_sel_e load_sel;
    logic      load_last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic replay_need;
    logic has_main;
    logic need_nl;
    logic need_nl_q;
    logic replay_last;
  } dp_status_t;

  // Whitespace is space, tab, LF, VT, FF and CR.
  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

endpackage

/* sv/epl_ctrl.sv */
`timescale 1ns / 1ps

module epl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  epl_pkg::dp_status_t   status_i,
  output epl_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLAY,
    ST_MAIN,
    ST_TAIL
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Input is taken only when idle and the output register can take a beat.
  assign in_stall_o = !((state_q == ST_IDLE) && status_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Sequencing of the beats caused by one input byte.
  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.load_sel     = epl_pkg::LOAD_NONE;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (status_i.replay_need) begin
            cmd_o.replay_start = 1'b1;
            state_d            = ST_REPLAY;
          end else if (status_i.has_main) begin
            cmd_o.load_sel  = epl_pkg::LOAD_NOW;
            cmd_o.load_last = !status_i.need_nl;
            if (status_i.need_nl) begin
              state_d = ST_TAIL;
            end
          end
        end
      end
      ST_REPLAY: begin
        if (status_i.out_free) begin
          cmd_o.load_sel = epl_pkg::LOAD_REPLAY;
          if (status_i.replay_last) begin
            state_d = ST_MAIN;
          end else begin
            cmd_o.replay_next = 1'b1;
          end
        end
      end
      ST_MAIN: begin
        if (status_i.out_free) begin
          cmd_o.load_sel  = epl_pkg::LOAD_MAIN;
          cmd_o.load_last = !status_i.need_nl_q;
          state_d         = status_i.need_nl_q ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (status_i.out_free) begin
          cmd_o.load_sel  = epl_pkg::LOAD_NL;
          cmd_o.load_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  // A beat is never loaded over one that the receiver still holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_sel != epl_pkg::LOAD_NONE) |-> status_i.out_free)
    else $error("beat loaded while output register busy");

  // A directive with held whitespace always starts a replay.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_i.replay_need) |=> (state_q == ST_REPLAY))
    else $error("replay not started");

  // The appended newline follows the main beat when one is owed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAIN && status_i.out_free && status_i.need_nl_q)
      |=> (state_q == ST_TAIL))
    else $error("final newline skipped");
`endif

endmodule

/* sv/epl_datapath.sv */
`timescale 1ns / 1ps

module epl_datapath #(
  parameter int unsigned LINE_MAX = epl_pkg::LINE_MAX_DEF,
  parameter int unsigned LEAD_MAX = epl_pkg::LEAD_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            in_byte_i,
  input  logic                  final_req_i,
  input  epl_pkg::ctrl_cmd_t    cmd_i,
  output epl_pkg::dp_status_t   status_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_byte_o,
  output logic                  last_of_run_o,
  output logic                  ws_truncated_o,
  output logic                  line_too_long_o
);

  localparam int unsigned LenW  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int unsigned LeadW = $clog2(LEAD_MAX + 1);
  localparam int unsigned AddrW = (LEAD_MAX > 1) ? $clog2(LEAD_MAX) : 1;
  localparam logic [LenW-1:0]  LenLimit = LenW'(LINE_MAX - 1);
  localparam logic [LeadW-1:0] LeadFull = LeadW'(LEAD_MAX);

  typedef enum logic [1:0] {
    MODE_LEAD,
    MODE_PASS,
    MODE_SKIP,
    MODE_ERR
  } line_mode_e;

  // Line state.
  line_mode_e       mode_q, mode_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LeadW-1:0] lead_cnt_q, lead_cnt_d;
  logic             lead_ovf_q, lead_ovf_d;
  logic             bslash_q, bslash_d;

  // Held leading whitespace.
  logic [7:0]       lead_mem [LEAD_MAX];
  logic             wr_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data_q;

  // Replay sequencing and the latched main beat.
  logic [LeadW-1:0] idx_q, replay_cnt_q;
  logic [7:0]       main_byte_q, main_byte;
  logic             main_trunc_q, main_trunc;
  logic             main_err_q, main_err;
  logic             need_nl_q, need_nl;
  logic             has_main, replay_need;

  // Output register.
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q, out_trunc_q, out_err_q;
  logic             out_free;

  logic             b_ws;

  assign b_ws     = epl_pkg::is_space(in_byte_i);
  assign out_free = !out_valid_q || !out_stall_i;

  // Decode of the presented byte against the line state.
  always_comb begin
    mode_d      = mode_q;
    len_d       = len_q;
    lead_cnt_d  = lead_cnt_q;
    lead_ovf_d  = lead_ovf_q;
    bslash_d    = bslash_q;
    wr_en       = 1'b0;
    has_main    = 1'b0;
    replay_need = 1'b0;
    main_byte   = in_byte_i;
    main_trunc  = 1'b0;
    main_err    = 1'b0;
    need_nl     = 1'b0;
    if (mode_q != MODE_ERR) begin
      if (in_byte_i == epl_pkg::CHAR_NL) begin
        if (mode_q == MODE_PASS) begin
          has_main = 1'b1;
          mode_d   = bslash_q ? MODE_PASS : MODE_LEAD;
        end else begin
          mode_d = MODE_LEAD;
        end
        len_d      = '0;
        lead_cnt_d = '0;
        lead_ovf_d = 1'b0;
        bslash_d   = 1'b0;
      end else if (len_q >= LenLimit) begin
        has_main  = 1'b1;
        main_byte = 8'h00;
        main_err  = 1'b1;
        mode_d    = MODE_ERR;
      end else begin
        len_d = len_q + LenW'(1);
        case (mode_q)
          MODE_LEAD: begin
            if (b_ws) begin
              if (lead_cnt_q < LeadFull) begin
                wr_en      = 1'b1;
                lead_cnt_d = lead_cnt_q + LeadW'(1);
              end else begin
                lead_ovf_d = 1'b1;
              end
            end else if (in_byte_i == epl_pkg::CHAR_HASH) begin
              has_main    = 1'b1;
              replay_need = (lead_cnt_q != '0);
              main_trunc  = lead_ovf_q;
              mode_d      = MODE_PASS;
              bslash_d    = 1'b0;
              lead_cnt_d  = '0;
              lead_ovf_d  = 1'b0;
            end else begin
              mode_d     = MODE_SKIP;
              lead_cnt_d = '0;
              lead_ovf_d = 1'b0;
            end
          end
          MODE_PASS: begin
            has_main = 1'b1;
            if (!b_ws) begin
              bslash_d = (in_byte_i == epl_pkg::CHAR_BSLASH);
            end
          end
          default: begin
          end
        endcase
      end
    end
    // The last byte of a file closes an open passed line and resets the line state.
    if (final_req_i) begin
      need_nl    = (mode_d == MODE_PASS) && (len_d != '0);
      mode_d     = MODE_LEAD;
      len_d      = '0;
      lead_cnt_d = '0;
      lead_ovf_d = 1'b0;
      bslash_d   = 1'b0;
    end
  end

  // Line state registers, updated once per accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_LEAD;
      len_q      <= '0;
      lead_cnt_q <= '0;
      lead_ovf_q <= 1'b0;
      bslash_q   <= 1'b0;
    end else if (cmd_i.accept) begin
      mode_q     <= mode_d;
      len_q      <= len_d;
      lead_cnt_q <= lead_cnt_d;
      lead_ovf_q <= lead_ovf_d;
      bslash_q   <= bslash_d;
    end
  end

  // Replay read address: first entry on start, then one entry per beat sent.
  always_comb begin
    if (cmd_i.replay_start) begin
      rd_addr = '0;
    end else if (cmd_i.replay_next) begin
      rd_addr = AddrW'(idx_q + LeadW'(1));
    end else begin
      rd_addr = AddrW'(idx_q);
    end
  end

  // Whitespace buffer with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_en) begin
      lead_mem[lead_cnt_q[AddrW-1:0]] <= in_byte_i;
    end
    rd_data_q <= lead_mem[rd_addr];
  end

  // Main beat latch and replay counters.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      main_byte_q  <= main_byte;
      main_trunc_q <= main_trunc;
      main_err_q   <= main_err;
      replay_cnt_q <= lead_cnt_q;
    end
    if (cmd_i.replay_start) begin
      idx_q <= '0;
    end else if (cmd_i.replay_next) begin
      idx_q <= idx_q + LeadW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_nl_q <= 1'b0;
    end else if (cmd_i.accept) begin
      need_nl_q <= need_nl;
    end
  end

  // Output register holds one beat until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_sel != epl_pkg::LOAD_NONE) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.load_sel)
      epl_pkg::LOAD_NOW: begin
        out_byte_q  <= main_byte;
        out_trunc_q <= main_trunc;
        out_err_q   <= main_err;
        out_last_q  <= cmd_i.load_last;
      end
      epl_pkg::LOAD_REPLAY: begin
        out_byte_q  <= rd_data_q;
        out_trunc_q <= 1'b0;
        out_err_q   <= 1'b0;
        out_last_q  <= cmd_i.load_last;
      end
      epl_pkg::LOAD_MAIN: begin
        out_byte_q  <= main_byte_q;
        out_trunc_q <= main_trunc_q;
        out_err_q   <= main_err_q;
        out_last_q  <= cmd_i.load_last;
      end
      epl_pkg::LOAD_NL: begin
        out_byte_q  <= epl_pkg::CHAR_NL;
        out_trunc_q <= 1'b0;
        out_err_q   <= 1'b0;
        out_last_q  <= cmd_i.load_last;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign last_of_run_o   = out_last_q;
  assign ws_truncated_o  = out_trunc_q;
  assign line_too_long_o = out_err_q;

  // Status toward the controller.
  assign status_o.out_free    = out_free;
  assign status_o.replay_need = replay_need;
  assign status_o.has_main    = has_main;
  assign status_o.need_nl     = need_nl;
  assign status_o.need_nl_q   = need_nl_q;
  assign status_o.replay_last =
    ((LeadW + 1)'(idx_q) + (LeadW + 1)'(1)) == (LeadW + 1)'(replay_cnt_q);

`ifndef ASSERT_OFF
  // The whitespace count never passes the buffer depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lead_cnt_q <= LeadFull)
    else $error("whitespace count beyond buffer");

  // The line length never passes the limit that triggers the error beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenLimit)
    else $error("line length beyond limit");
`endif

endmodule

/* sv/extract_preprocessor_lines.sv */
`timescale 1ns / 1ps

// Preprocessor line extractor.
// Input channel (in_valid_i / in_stall_o): one beat per byte of a text file,
// with final_req_i high on the last byte of the file. Output channel
// (out_valid_o / out_stall_i): one beat per byte of extracted text; the
// last_of_run_o flag marks the final beat caused by one input byte.
// Throughput: one input byte per cycle while no beats back up and no byte
// is still sending extra beats, which stalls the input. A '#' that follows
// held whitespace bytes is handled as an accept step, a read of the whitespace
// buffer per held byte, then the '#', plus an appended newline when it also
// carries final_req_i and one is owed. Any other final byte that closes a
// passed line also sends an appended newline. The first beat of a byte comes
// from the output register; a replayed whitespace run is first read from a
// registered memory. Reset clears the line state and the output register; no
// clearing pass is needed. When the receiver stalls, the output beat holds
// and the input is stalled until the output register frees up.
module extract_preprocessor_lines #(
  parameter int unsigned LINE_MAX = epl_pkg::LINE_MAX_DEF,
  parameter int unsigned LEAD_MAX = epl_pkg::LEAD_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       final_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       ws_truncated_o,
  output logic       line_too_long_o
);

  epl_pkg::ctrl_cmd_t  cmd;
  epl_pkg::dp_status_t status;

  // Sequencer for the beats of each input byte.
  epl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Line state, whitespace buffer and output register.
  epl_datapath #(
    .LINE_MAX (LINE_MAX),
    .LEAD_MAX (LEAD_MAX)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_byte_i       (in_byte_i),
    .final_req_i     (final_req_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o),
    .ws_truncated_o  (ws_truncated_o),
    .line_too_long_o (line_too_long_o)
  );

endmodule
